FILE: rtl/core/bmpc_pkg.sv
// Shared types and constants for the bus mouse counter port.
package bmpc_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_MOVE  = 2'd2,
    ACT_TICK  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    PORT_A    = 2'd0,
    PORT_B    = 2'd1,
    PORT_C    = 2'd2,
    PORT_CTRL = 2'd3
  } port_t;

  localparam logic [7:0] MODE_DEFAULT_WORD = 8'h93;
  localparam logic [7:0] PC_RESET          = 8'h10;

  // port C bit positions
  localparam int PC_HOLD_BIT     = 7;
  localparam int PC_SEL_Y_BIT    = 6;
  localparam int PC_SEL_HIGH_BIT = 5;
  localparam int PC_IRQ_MASK_BIT = 4;

  // control word with this bit set is a mode word
  localparam int CTRL_MODE_BIT = 7;

  localparam logic [7:0] NIBBLE_MASK   = 8'h0f;
  localparam logic [7:0] PA_LEFT_UP    = 8'h80;
  localparam logic [7:0] PA_RIGHT_UP   = 8'h20;
  localparam logic [7:0] PA_FIXED_ONES = 8'h50;

  localparam logic [15:0] PERIOD_RESET = 16'd1;

  // register byte addresses on the config port
  localparam logic [2:0] ADDR_IRQ_PERIOD = 3'd0;

endpackage

FILE: rtl/core/bus_mouse_ppi_counter_port_unit.sv
// Bus mouse counter port behind a parallel port interface: top level.
// Takes one word per clock unless stalled; returns one result word per input word,
// from a single output register; input is stalled only while that register holds an
// untaken result. Movement words add saturating signed deltas to the X/Y counters and
// latch the buttons; a rising hold bit on a port C write moves the counters into the
// held copies and clears them; port A reads return a nibble of a held copy with button
// and fixed bits; ticks count toward irq_period_ticks (APB offset 0, reset 1, zero acts
// as one) and pulse irq_pulse unless port C bit 4 masks it. Non-read results carry zero
// read_data.
module bus_mouse_ppi_counter_port_unit (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  action,
  input  logic [1:0]  port_index,
  input  logic [7:0]  write_data,
  input  logic signed [7:0] move_dx,
  input  logic signed [7:0] move_dy,
  input  logic        left_pressed,
  input  logic        right_pressed,
  // result words
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  read_data,
  output logic        read_valid,
  output logic        irq_pulse,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] irq_period_ticks;
  logic [7:0]  port_c_latch, port_c_latch_next;
  logic [7:0]  mode_word, mode_word_next;
  logic [7:0]  x_counter, x_counter_next;
  logic [7:0]  y_counter, y_counter_next;
  logic [7:0]  x_held, x_held_next;
  logic [7:0]  y_held, y_held_next;
  logic [1:0]  button_bits, button_bits_next;
  logic [15:0] tick_count, tick_count_next;

  logic [7:0]  read_data_next;
  logic        read_valid_next;
  logic        irq_pulse_next;

  logic        accept;
  logic        cfg_write;
  logic [16:0] tick_inc;
  logic [7:0]  sel_src;
  logic [7:0]  port_a_value;

  assign item_stall = result_valid & result_stall;
  assign accept     = item_valid & ~item_stall;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign prdata    = (paddr == bmpc_pkg::ADDR_IRQ_PERIOD) ? {16'd0, irq_period_ticks} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      irq_period_ticks <= bmpc_pkg::PERIOD_RESET;
    end else if (cfg_write && paddr == bmpc_pkg::ADDR_IRQ_PERIOD) begin
      irq_period_ticks <= pwdata[15:0];
    end
  end

  function automatic logic [7:0] sat_add(input logic [7:0] cnt, input logic [7:0] delta);
    logic signed [8:0] sum;
    begin
      sum = $signed({cnt[7], cnt}) + $signed({delta[7], delta});
      if (sum > 9'sd127) begin
        sat_add = 8'h7f;
      end else if (sum < -9'sd128) begin
        sat_add = 8'h80;
      end else begin
        sat_add = sum[7:0];
      end
    end
  endfunction

  always_comb begin
    sel_src = port_c_latch[bmpc_pkg::PC_SEL_Y_BIT] ? y_held : x_held;
    if (port_c_latch[bmpc_pkg::PC_SEL_HIGH_BIT]) begin
      sel_src = {4'd0, sel_src[7:4]};
    end
    port_a_value = (sel_src & bmpc_pkg::NIBBLE_MASK) | bmpc_pkg::PA_FIXED_ONES;
    if (!button_bits[0]) port_a_value = port_a_value | bmpc_pkg::PA_LEFT_UP;
    if (!button_bits[1]) port_a_value = port_a_value | bmpc_pkg::PA_RIGHT_UP;
  end

  assign tick_inc = {1'b0, tick_count} + 17'd1;

  always_comb begin
    port_c_latch_next = port_c_latch;
    mode_word_next    = mode_word;
    x_counter_next    = x_counter;
    y_counter_next    = y_counter;
    x_held_next       = x_held;
    y_held_next       = y_held;
    button_bits_next  = button_bits;
    tick_count_next   = tick_count;
    read_data_next    = 8'd0;
    read_valid_next   = 1'b0;
    irq_pulse_next    = 1'b0;

    case (action)
      bmpc_pkg::ACT_WRITE: begin
        if (port_index == bmpc_pkg::PORT_C) begin
          // hold snapshot only on a low-to-high edge of bit 7
          if (write_data[bmpc_pkg::PC_HOLD_BIT] && !port_c_latch[bmpc_pkg::PC_HOLD_BIT]) begin
            x_held_next    = x_counter;
            y_held_next    = y_counter;
            x_counter_next = 8'd0;
            y_counter_next = 8'd0;
          end
          port_c_latch_next = write_data;
        end else if (port_index == bmpc_pkg::PORT_CTRL) begin
          if (write_data[bmpc_pkg::CTRL_MODE_BIT]) mode_word_next = write_data;
        end
      end
      bmpc_pkg::ACT_READ: begin
        read_valid_next = 1'b1;
        case (port_index)
          bmpc_pkg::PORT_A:    read_data_next = port_a_value;
          bmpc_pkg::PORT_C:    read_data_next = port_c_latch;
          bmpc_pkg::PORT_CTRL: read_data_next = mode_word;
          default:             read_data_next = 8'd0;
        endcase
      end
      bmpc_pkg::ACT_MOVE: begin
        x_counter_next   = sat_add(x_counter, move_dx);
        y_counter_next   = sat_add(y_counter, move_dy);
        button_bits_next = {right_pressed, left_pressed};
      end
      default: begin
        // a period of zero behaves as one since the increment is always at least one
        if (tick_inc >= {1'b0, irq_period_ticks}) begin
          tick_count_next = 16'd0;
          irq_pulse_next  = ~port_c_latch[bmpc_pkg::PC_IRQ_MASK_BIT];
        end else begin
          tick_count_next = tick_inc[15:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      port_c_latch <= bmpc_pkg::PC_RESET;
      mode_word    <= 8'd0;
      x_counter    <= 8'd0;
      y_counter    <= 8'd0;
      x_held       <= 8'd0;
      y_held       <= 8'd0;
      button_bits  <= 2'd0;
      tick_count   <= 16'd0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        port_c_latch <= port_c_latch_next;
        mode_word    <= mode_word_next;
        x_counter    <= x_counter_next;
        y_counter    <= y_counter_next;
        x_held       <= x_held_next;
        y_held       <= y_held_next;
        button_bits  <= button_bits_next;
        tick_count   <= tick_count_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      read_data  <= read_data_next;
      read_valid <= read_valid_next;
      irq_pulse  <= irq_pulse_next;
    end
  end

`ifndef SYNTH
  a_read_gives_read_result: assert property (@(posedge clk) disable iff (rst)
    (accept && action == bmpc_pkg::ACT_READ) |=> (result_valid && read_valid))
    else $error("bus read did not produce a read result");

  a_irq_not_on_read: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(read_valid && irq_pulse))
    else $error("interrupt pulse on a read result");

  a_data_zero_off_read: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !read_valid) |-> (read_data == 8'd0))
    else $error("nonzero read data on a non-read result");

  a_masked_no_irq: assert property (@(posedge clk) disable iff (rst)
    (accept && port_c_latch[bmpc_pkg::PC_IRQ_MASK_BIT]) |=> !irq_pulse)
    else $error("interrupt pulse while masked");
`endif

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// Testbench for the bus mouse counter port: directed and random words checked against a predictor.
module tb;

  localparam int LIMIT_CYCLES = 400000;

  typedef struct {
    bmpc_pkg::action_t act;
    bmpc_pkg::port_t   port;
    logic [7:0]        wdata;
    logic signed [7:0] dx;
    logic signed [7:0] dy;
    logic              left;
    logic              right;
  } word_t;

  typedef struct {
    logic [7:0] rdata;
    logic       rvalid;
    logic       irq;
  } answer_t;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_COMB, STALL_BURSTY} stall_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              item_valid = 1'b0;
  logic              item_stall;
  logic [1:0]        action = '0;
  logic [1:0]        port_index = '0;
  logic [7:0]        write_data = '0;
  logic signed [7:0] move_dx = '0;
  logic signed [7:0] move_dy = '0;
  logic              left_pressed = 1'b0;
  logic              right_pressed = 1'b0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic [7:0]        read_data;
  logic              read_valid;
  logic              irq_pulse;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // predictor state
  logic [15:0] m_period;
  logic [15:0] m_tick;
  logic [7:0]  m_pc;
  logic [7:0]  m_mode;
  logic [7:0]  m_x;
  logic [7:0]  m_y;
  logic [7:0]  m_x_held;
  logic [7:0]  m_y_held;
  logic [1:0]  m_buttons;

  answer_t     port_answers[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          burst_left = 8;
  int          stall_count = 0;
  int          stall_hold = 0;
  stall_mode_t stall_mode = STALL_NONE;

  bus_mouse_ppi_counter_port_unit dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .action(action), .port_index(port_index), .write_data(write_data),
    .move_dx(move_dx), .move_dy(move_dy),
    .left_pressed(left_pressed), .right_pressed(right_pressed),
    .result_valid(result_valid), .result_stall(result_stall),
    .read_data(read_data), .read_valid(read_valid), .irq_pulse(irq_pulse),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  function automatic logic [7:0] sat_add8(logic [7:0] cnt, logic signed [7:0] d);
    int s;
    s = int'($signed(cnt)) + int'(d);
    if (s > 127) s = 127;
    if (s < -128) s = -128;
    return 8'(s);
  endfunction

  function automatic void reset_model();
    m_period  = bmpc_pkg::PERIOD_RESET;
    m_tick    = '0;
    m_pc      = bmpc_pkg::PC_RESET;
    m_mode    = '0;
    m_x       = '0;
    m_y       = '0;
    m_x_held  = '0;
    m_y_held  = '0;
    m_buttons = '0;
  endfunction

  function automatic answer_t mouse_port_predict(word_t w);
    answer_t    a;
    logic [7:0] src;
    logic [7:0] v;
    int         next_tick;
    a = '{rdata: 8'h00, rvalid: 1'b0, irq: 1'b0};
    case (w.act)
      bmpc_pkg::ACT_WRITE: begin
        if (w.port == bmpc_pkg::PORT_C) begin
          // only a rising hold bit takes a snapshot
          if (w.wdata[bmpc_pkg::PC_HOLD_BIT] && !m_pc[bmpc_pkg::PC_HOLD_BIT]) begin
            m_x_held = m_x;
            m_y_held = m_y;
            m_x = '0;
            m_y = '0;
          end
          m_pc = w.wdata;
        end else if (w.port == bmpc_pkg::PORT_CTRL && w.wdata[bmpc_pkg::CTRL_MODE_BIT]) begin
          m_mode = w.wdata;
        end
      end
      bmpc_pkg::ACT_READ: begin
        a.rvalid = 1'b1;
        case (w.port)
          bmpc_pkg::PORT_A: begin
            src = m_pc[bmpc_pkg::PC_SEL_Y_BIT] ? m_y_held : m_x_held;
            v = m_pc[bmpc_pkg::PC_SEL_HIGH_BIT] ? (src >> 4) : src;
            v = (v & bmpc_pkg::NIBBLE_MASK) | bmpc_pkg::PA_FIXED_ONES;
            if (!m_buttons[0]) v = v | bmpc_pkg::PA_LEFT_UP;
            if (!m_buttons[1]) v = v | bmpc_pkg::PA_RIGHT_UP;
            a.rdata = v;
          end
          bmpc_pkg::PORT_C:    a.rdata = m_pc;
          bmpc_pkg::PORT_CTRL: a.rdata = m_mode;
          default:             a.rdata = 8'h00;
        endcase
      end
      bmpc_pkg::ACT_MOVE: begin
        m_x = sat_add8(m_x, w.dx);
        m_y = sat_add8(m_y, w.dy);
        m_buttons = {w.right, w.left};
      end
      default: begin
        // zero period compares like a period of one
        next_tick = int'(m_tick) + 1;
        if (next_tick >= int'(m_period)) begin
          m_tick = '0;
          if (!m_pc[bmpc_pkg::PC_IRQ_MASK_BIT]) a.irq = 1'b1;
        end else begin
          m_tick = 16'(next_tick);
        end
      end
    endcase
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (!rst && result_valid && !result_stall) begin
      if (port_answers.size() == 0) begin
        report_mismatch("result word with none expected", 32'(read_data), 32'd0);
      end else begin
        want = port_answers.pop_front();
        if (read_data !== want.rdata)
          report_mismatch("read_data", 32'(read_data), 32'(want.rdata));
        if (read_valid !== want.rvalid)
          report_mismatch("read_valid", 32'(read_valid), 32'(want.rvalid));
        if (irq_pulse !== want.irq)
          report_mismatch("irq_pulse", 32'(irq_pulse), 32'(want.irq));
      end
    end
  end

  // receiver stall pattern, switching among four styles at random
  always @(negedge clk) begin
    stall_count++;
    if (stall_count % 256 == 0) stall_mode = stall_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE: result_stall <= 1'b0;
      STALL_COIN: result_stall <= 1'($urandom_range(0, 1));
      STALL_COMB: result_stall <= (stall_count % 7) < 3;
      default: begin
        if (stall_hold > 0) begin
          stall_hold--;
          result_stall <= 1'b1;
        end else begin
          if ($urandom_range(0, 15) == 0) stall_hold = $urandom_range(3, 12);
          result_stall <= 1'b0;
        end
      end
    endcase
  end

  task automatic send_word(word_t w);
    @(negedge clk);
    action        <= w.act;
    port_index    <= w.port;
    write_data    <= w.wdata;
    move_dx       <= w.dx;
    move_dy       <= w.dy;
    left_pressed  <= w.left;
    right_pressed <= w.right;
    item_valid    <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    port_answers.push_back(mouse_port_predict(w));
  endtask

  task automatic idle_sender(int n);
    @(negedge clk);
    item_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_paced(word_t w);
    send_word(w);
    burst_left--;
    if (burst_left <= 0) begin
      idle_sender($urandom_range(1, 5));
      burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
    end
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    item_valid <= 1'b0;
    while (port_answers.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_period(logic [15:0] val);
    wait_results_drained();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= bmpc_pkg::ADDR_IRQ_PERIOD;
    pwdata  <= {16'h0000, val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    m_period = val;
    // read it back
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {16'h0000, val})
      report_mismatch("irq period readback", prdata, {16'h0000, val});
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic word_t noise_word(bmpc_pkg::action_t a, bmpc_pkg::port_t p,
                                       logic [7:0] d);
    word_t w;
    w.act   = a;
    w.port  = p;
    w.wdata = d;
    w.dx    = 8'($urandom_range(0, 255));
    w.dy    = 8'($urandom_range(0, 255));
    w.left  = 1'($urandom_range(0, 1));
    w.right = 1'($urandom_range(0, 1));
    return w;
  endfunction

  function automatic logic [7:0] random_delta();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return $urandom_range(0, 1) ? 8'h7f : 8'h80;
    if (pick < 5) return 8'($urandom_range(0, 31)) - 8'd16;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic bus_write(bmpc_pkg::port_t p, logic [7:0] d);
    send_paced(noise_word(bmpc_pkg::ACT_WRITE, p, d));
  endtask

  task automatic bus_read(bmpc_pkg::port_t p);
    send_paced(noise_word(bmpc_pkg::ACT_READ, p, 8'($urandom_range(0, 255))));
  endtask

  task automatic mouse_move(logic [7:0] dx, logic [7:0] dy, logic l, logic r);
    word_t w;
    w = noise_word(bmpc_pkg::ACT_MOVE, bmpc_pkg::port_t'($urandom_range(0, 3)),
                   8'($urandom_range(0, 255)));
    w.dx    = dx;
    w.dy    = dy;
    w.left  = l;
    w.right = r;
    send_paced(w);
  endtask

  task automatic tick();
    send_paced(noise_word(bmpc_pkg::ACT_TICK, bmpc_pkg::port_t'($urandom_range(0, 3)),
                          8'($urandom_range(0, 255))));
  endtask

  function automatic word_t random_word();
    word_t w;
    int    pick;
    w = noise_word(bmpc_pkg::ACT_READ, bmpc_pkg::port_t'($urandom_range(0, 3)),
                   8'($urandom_range(0, 255)));
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      w.act = bmpc_pkg::ACT_MOVE;
      w.dx  = random_delta();
      w.dy  = random_delta();
    end else if (pick < 50) begin
      w.act = bmpc_pkg::ACT_TICK;
    end else if (pick >= 75) begin
      w.act = bmpc_pkg::ACT_WRITE;
      if ($urandom_range(0, 3) != 0) w.port = bmpc_pkg::PORT_C;
      // keep the interrupt unmasked most of the time
      if (w.port == bmpc_pkg::PORT_C && $urandom_range(0, 2) != 0)
        w.wdata[bmpc_pkg::PC_IRQ_MASK_BIT] = 1'b0;
    end
    return w;
  endfunction

  // moves, a hold edge, then nibble reads under changing selects
  task automatic snapshot_sequence(output int n);
    logic [7:0] pc;
    int         moves;
    int         reads;
    moves = $urandom_range(1, 6);
    reads = $urandom_range(1, 4);
    repeat (moves) mouse_move(random_delta(), random_delta(), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
    pc = 8'($urandom_range(0, 255));
    pc[bmpc_pkg::PC_HOLD_BIT] = 1'b0;
    bus_write(bmpc_pkg::PORT_C, pc);
    pc[bmpc_pkg::PC_HOLD_BIT] = 1'b1;
    bus_write(bmpc_pkg::PORT_C, pc);
    repeat (reads) begin
      pc[bmpc_pkg::PC_SEL_Y_BIT]    = 1'($urandom_range(0, 1));
      pc[bmpc_pkg::PC_SEL_HIGH_BIT] = 1'($urandom_range(0, 1));
      bus_write(bmpc_pkg::PORT_C, pc);
      bus_read(bmpc_pkg::PORT_A);
    end
    n = moves + 2 + 2 * reads;
  endtask

  task automatic test_reset_state();
    bus_read(bmpc_pkg::PORT_A);
    bus_read(bmpc_pkg::PORT_C);
    bus_read(bmpc_pkg::PORT_CTRL);
  endtask

  task automatic test_bus_writes();
    bus_write(bmpc_pkg::PORT_A, 8'hff);
    bus_write(bmpc_pkg::PORT_B, 8'hff);
    bus_read(bmpc_pkg::PORT_B);
    bus_write(bmpc_pkg::PORT_CTRL, 8'h7f);   // bit set/reset word, ignored
    bus_write(bmpc_pkg::PORT_CTRL, bmpc_pkg::MODE_DEFAULT_WORD);
    bus_read(bmpc_pkg::PORT_CTRL);
  endtask

  task automatic test_hold_and_nibbles();
    mouse_move(8'h7f, 8'h7f, 1'b1, 1'b0);
    mouse_move(8'h7f, 8'h7f, 1'b0, 1'b1);
    bus_write(bmpc_pkg::PORT_C, 8'h80);
    bus_read(bmpc_pkg::PORT_A);
    mouse_move(8'h80, 8'h80, 1'b1, 1'b1);
    mouse_move(8'h80, 8'hff, 1'b0, 1'b0);
    bus_write(bmpc_pkg::PORT_C, 8'he0);      // hold still high: no new snapshot
    bus_read(bmpc_pkg::PORT_A);
    bus_write(bmpc_pkg::PORT_C, 8'h40);
    bus_write(bmpc_pkg::PORT_C, 8'ha0);
    bus_read(bmpc_pkg::PORT_A);
    bus_read(bmpc_pkg::PORT_C);
  endtask

  task automatic test_irq_period();
    bus_write(bmpc_pkg::PORT_C, 8'h00);
    write_period(16'd0);
    tick();
    tick();
    write_period(16'hffff);
    repeat (3) tick();
    write_period(16'd2);           // now below the running count
    repeat (3) tick();
    bus_write(bmpc_pkg::PORT_C, bmpc_pkg::PC_RESET);   // masked
    repeat (2) tick();
  endtask

  task automatic test_random_traffic(logic [15:0] period, int words);
    int done;
    int n;
    write_period(period);
    done = 0;
    while (done < words) begin
      if ($urandom_range(0, 199) == 0) wait_results_drained();
      if ($urandom_range(0, 3) == 0) begin
        snapshot_sequence(n);
        done += n;
      end else begin
        send_paced(random_word());
        done++;
      end
    end
  endtask

  initial begin
    reset_model();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_bus_writes();
    test_hold_and_nibbles();
    test_irq_period();
    test_random_traffic(16'd1, 140);
    test_random_traffic(16'd3, 140);
    test_random_traffic(16'($urandom_range(2, 9)), 140);
    test_random_traffic(16'hffff, 140);
    test_random_traffic(16'd0, 140);
    test_random_traffic(16'($urandom_range(1, 16)), 140);

    wait_results_drained();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
